[rtl/kvt_pkg.sv]
// Package for the key/value table: state encoding, command and status codes,
// and the widths of the stream payloads. Used by the top level and the checker under rtl.
package kvt_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned ValW    = 32;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;
  localparam int unsigned EntryW  = KeyW + ValW;

  localparam int unsigned InBits   = CmdW + KeyW + ValW;
  localparam int unsigned OutBits  = StatusW + ValW + CountW;
  localparam int unsigned InDataW  = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_FOUND   = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

endpackage

[rtl/kvt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; holds the key/value entries of the table.
module kvt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

[rtl/key_value_table_unit.sv]
// Key/value table top level: sequencer, compare unit and entry RAM.
// Depends on kvt_pkg and kvt_ram.
//
// The block keeps up to DEPTH key/value pairs as a compact unsorted list.
// Each slave-side transaction carries a command (add, search, remove), a
// key and a value; each one yields exactly one master-side transaction
// with a status, the old or found value and the entry count afterwards.
// The key compare and the RAM read port form one shared unit that walks
// the list one entry per cycle; a remove then walks the rest of the list
// again, moving each later entry down by one place.
// The walk stops at the first matching entry, or after the last entry
// when the key is missing; the result is then registered in S_RESP.
// The next transaction can be accepted in the same cycle as the result appears.
// The slave side is ready only while the block is idle, so one item is
// in work at a time. A result waits in an output register; the block may
// take the next item while it waits, and holds its own next result until
// the receiver takes the previous one.
// Reset empties the table at once; no clearing pass is needed.
module key_value_table_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // cmd [1:0], key [33:2], value [65:34], zero fill to the top.
  input  logic [kvt_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status [1:0], old_value [33:2], entry_count [38:34], zero fill on top.
  output logic [kvt_pkg::OutDataW-1:0]   m_axis_tdata
);
  import kvt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e                state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         rd_idx_q, rd_idx_d;
  logic [CW-1:0]         cmp_idx_q, cmp_idx_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic                  out_vld_q, out_vld_d;
  logic [CmdW-1:0]       cmd_q, cmd_d;
  logic [KeyW-1:0]       key_q, key_d;
  logic [ValW-1:0]       val_q, val_d;
  logic [StatusW-1:0]    status_q, status_d;
  logic [ValW-1:0]       old_q, old_d;
  logic [OutDataW-1:0]   out_data_q, out_data_d;

  logic                  rd_en;
  logic [EntryW-1:0]     rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [EntryW-1:0]     wr_data;
  logic [KeyW-1:0]       rd_key;
  logic [ValW-1:0]       rd_val;
  logic                  hit;
  logic                  walk_done;
  logic                  in_acc;
  logic                  out_free;
  logic [CW-1:0]         shift_dst;

  assign rd_key    = rd_data[KeyW-1:0];
  assign rd_val    = rd_data[EntryW-1:KeyW];
  assign hit       = cmp_vld_q && (rd_key == key_q);
  assign walk_done = !cmp_vld_q && (rd_idx_q >= cnt_q);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_vld_q || m_axis_tready;
  assign shift_dst = cmp_idx_q - CW'(1);

  kvt_ram #(
    .WIDTH(EntryW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_idx_q[AW-1:0]),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tdata[CmdW-1:0] inside {CMD_ADD, CMD_SEARCH, CMD_REMOVE}) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = (cmd_q == CMD_REMOVE) ? S_SHIFT : S_RESP;
        end else if (walk_done) begin
          state_d = S_RESP;
        end
      end
      S_SHIFT: begin
        if (walk_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    cnt_d         = cnt_q;
    rd_idx_d      = rd_idx_q;
    cmp_idx_d     = cmp_idx_q;
    cmp_vld_d     = cmp_vld_q;
    cmd_d         = cmd_q;
    key_d         = key_q;
    val_d         = val_q;
    status_d      = status_q;
    old_d         = old_q;
    out_data_d    = out_data_q;
    out_vld_d     = out_vld_q && !m_axis_tready;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = cmp_idx_q[AW-1:0];
    wr_data       = {val_q, key_q};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d     = s_axis_tdata[CmdW-1:0];
          key_d     = s_axis_tdata[CmdW+KeyW-1:CmdW];
          val_d     = s_axis_tdata[InBits-1:CmdW+KeyW];
          rd_idx_d  = '0;
          cmp_vld_d = 1'b0;
          status_d  = ST_MISSING;
          old_d     = '0;
        end
      end
      S_SCAN: begin
        rd_en     = (rd_idx_q < cnt_q);
        rd_idx_d  = rd_en ? rd_idx_q + CW'(1) : rd_idx_q;
        cmp_vld_d = rd_en;
        cmp_idx_d = rd_idx_q;
        if (hit) begin
          status_d  = ST_FOUND;
          old_d     = rd_val;
          cmp_vld_d = 1'b0;
          if (cmd_q == CMD_ADD) begin
            wr_en = 1'b1;
          end
          if (cmd_q == CMD_REMOVE) begin
            rd_idx_d = cmp_idx_q + CW'(1);
          end
        end else if (walk_done && cmd_q == CMD_ADD) begin
          if (cnt_q == CW'(DEPTH)) begin
            status_d = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = cnt_q[AW-1:0];
            cnt_d   = cnt_q + CW'(1);
          end
        end
      end
      S_SHIFT: begin
        rd_en     = (rd_idx_q < cnt_q);
        rd_idx_d  = rd_en ? rd_idx_q + CW'(1) : rd_idx_q;
        cmp_vld_d = rd_en;
        cmp_idx_d = rd_idx_q;
        if (cmp_vld_q) begin
          wr_en   = 1'b1;
          wr_addr = shift_dst[AW-1:0];
          wr_data = rd_data;
        end
        if (walk_done) begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = '0;
          out_data_d[StatusW-1:0]              = status_q;
          out_data_d[StatusW+ValW-1:StatusW]   = old_q;
          out_data_d[OutBits-1:StatusW+ValW]   = CountW'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    val_q      <= val_d;
    status_q   <= status_d;
    old_q      <= old_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[rtl/kvt_checker.sv]
// Port-level assertions for the key/value table, bound to its top level.
// Depends on kvt_pkg and key_value_table_unit.
module kvt_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [kvt_pkg::OutDataW-1:0] m_axis_tdata
);
  import kvt_pkg::*;

  logic [StatusW-1:0] status;
  logic [ValW-1:0]    old_value;
  logic [CountW-1:0]  entry_count;

  assign status      = m_axis_tdata[StatusW-1:0];
  assign old_value   = m_axis_tdata[StatusW+ValW-1:StatusW];
  assign entry_count = m_axis_tdata[OutBits-1:StatusW+ValW];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input accepted while a transaction is in work.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (status == ST_FOUND || status == ST_MISSING || status == ST_FULL))
    else $error("Unknown status code.");

  a_zero_when_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status != ST_FOUND |-> old_value == '0)
    else $error("Nonzero value reported for an absent key.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (DEPTH > 31) || (32'(entry_count) <= DEPTH))
    else $error("Entry count above capacity.");

endmodule

bind key_value_table_unit kvt_checker #(.DEPTH(DEPTH)) u_kvt_checker (.*);

[verif/tb_top.sv]
// Self-checking testbench for key_value_table_unit: random and directed add, search,
// remove and unused-code transactions, with the expected results predicted by a small
// scoreboard class. Depends on kvt_pkg and the RTL under rtl.
`timescale 1ns / 100ps

module tb_top;
  import kvt_pkg::*;

  localparam int unsigned Depth     = 16;
  localparam logic [1:0]  CmdUnused = 2'd3;
  localparam int          WatchdogLimit = 2000;
  localparam int          PoolSize  = 24;
  localparam int          HoldCycles = 400;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [ValW-1:0]    old_value;
    logic [CountW-1:0]  entry_count;
  } kv_result_t;

  class kv_scoreboard;
    logic [KeyW-1:0] keys[Depth];
    logic [ValW-1:0] vals[Depth];
    int unsigned     used;
    kv_result_t      pending_q[$];
    int              errors;
    int              n_checked;
    int              n_items;
    int              n_appended, n_updated, n_rejected, n_hits, n_misses, n_removed;
    int              n_unused;
    int unsigned     peak;

    function new();
      used = 0;
      errors = 0;
      n_checked = 0;
      n_items = 0;
      n_appended = 0;
      n_updated = 0;
      n_rejected = 0;
      n_hits = 0;
      n_misses = 0;
      n_removed = 0;
      n_unused = 0;
      peak = 0;
    endfunction

    function void note_input(logic [InDataW-1:0] d);
      logic [1:0]      op;
      logic [KeyW-1:0] k;
      logic [ValW-1:0] v;
      kv_result_t      r;
      int unsigned     slot;
      int unsigned     j;
      op = d[1:0];
      k  = d[KeyW+1:2];
      v  = d[KeyW+ValW+1:KeyW+2];
      n_items++;
      slot = used;
      for (j = 0; j < used; j++) begin
        if (keys[j] == k) begin
          slot = j;
          break;
        end
      end
      r.status = ST_MISSING;
      r.old_value = '0;
      case (op)
        CMD_ADD: begin
          if (slot < used) begin
            r.old_value = vals[slot];
            vals[slot] = v;
            r.status = ST_FOUND;
            n_updated++;
          end else if (used >= Depth) begin
            r.status = ST_FULL;
            n_rejected++;
          end else begin
            keys[used] = k;
            vals[used] = v;
            used++;
            n_appended++;
          end
        end
        CMD_SEARCH: begin
          if (slot < used) begin
            r.old_value = vals[slot];
            r.status = ST_FOUND;
            n_hits++;
          end else begin
            n_misses++;
          end
        end
        CMD_REMOVE: begin
          if (slot < used) begin
            r.old_value = vals[slot];
            r.status = ST_FOUND;
            for (j = slot; j + 1 < used; j++) begin
              keys[j] = keys[j+1];
              vals[j] = vals[j+1];
            end
            used--;
            n_removed++;
          end else begin
            n_misses++;
          end
        end
        default: begin
          n_unused++;
        end
      endcase
      if (used > peak) peak = used;
      r.entry_count = used[CountW-1:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [OutDataW-1:0] d);
      kv_result_t exp_r;
      kv_result_t act_r;
      act_r.status      = d[StatusW-1:0];
      act_r.old_value   = d[StatusW+ValW-1:StatusW];
      act_r.entry_count = d[StatusW+ValW+CountW-1:StatusW+ValW];
      n_checked++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d old %h count %0d",
                 $time, act_r.status, act_r.old_value, act_r.entry_count);
        return;
      end
      exp_r = pending_q.pop_front();
      if (act_r.status !== exp_r.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, exp_r.status, act_r.status);
      end
      if (act_r.old_value !== exp_r.old_value) begin
        errors++;
        $display("%0t: old_value mismatch, expected %h, actual %h",
                 $time, exp_r.old_value, act_r.old_value);
      end
      if (act_r.entry_count !== exp_r.entry_count) begin
        errors++;
        $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                 $time, exp_r.entry_count, act_r.entry_count);
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  kv_scoreboard    sb;
  logic            calm = 1'b0;
  logic [KeyW-1:0] key_pool[PoolSize];
  int              quiet_cycles = 0;
  bit              hold_used = 1'b0;

  key_value_table_unit #(
    .DEPTH(Depth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.note_input(s_axis_tdata);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (!hold_used && sb.n_checked >= 150) begin
        hold_used = 1'b1;
        stall = HoldCycles;
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [KeyW-1:0] k,
                           input logic [ValW-1:0] v);
    while (!calm && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - InBits){1'b0}}, v, k, op};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(PoolSize - 1)];
    return $urandom;
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return 32'h8000_0000;
    if (r < 8) return 32'h7fff_ffff;
    if (r < 10) return '0;
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_cmd(input bit fill_bias);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return CmdUnused;
    if (fill_bias) begin
      if (r < 60) return CMD_ADD;
      if (r < 80) return CMD_SEARCH;
      return CMD_REMOVE;
    end
    if (r < 30) return CMD_ADD;
    if (r < 50) return CMD_SEARCH;
    return CMD_REMOVE;
  endfunction

  initial begin : stimulus
    int i;
    int phase;
    int count;
    sb = new();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (i = 4; i < PoolSize; i++) key_pool[i] = $urandom;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(CMD_ADD, key_pool[0], 32'h7fff_ffff);
    send_item(CMD_ADD, key_pool[1], 32'h8000_0000);
    send_item(CMD_ADD, key_pool[2], 32'h0000_0000);
    send_item(CMD_ADD, key_pool[3], 32'hffff_ffff);
    send_item(CMD_SEARCH, key_pool[1], $urandom);
    send_item(CMD_ADD, key_pool[2], 32'h1234_5678);
    send_item(CMD_REMOVE, key_pool[0], $urandom);
    send_item(CMD_SEARCH, key_pool[0], $urandom);
    send_item(CMD_REMOVE, key_pool[0], $urandom);
    send_item(CmdUnused, key_pool[3], $urandom);
    for (i = 4; i <= 16; i++) send_item(CMD_ADD, key_pool[i], $urandom);
    send_item(CMD_ADD, key_pool[17], $urandom);
    send_item(CMD_ADD, key_pool[1], 32'hffff_ffff);
    send_item(CMD_REMOVE, key_pool[16], $urandom);
    send_item(CMD_REMOVE, key_pool[1], $urandom);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait_drained();

    count = 0;
    for (phase = 0; phase < 4; phase++) begin
      for (i = 0; i < 138; i++) begin
        calm = (count >= 200 && count < 300);
        send_item(pick_cmd(phase % 2 == 0), pick_key(), pick_value());
        count++;
      end
      if (phase == 1) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        wait_drained();
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("Ran %0d commands: %0d appends, %0d updates, %0d rejected on full, %0d removes,",
             sb.n_items, sb.n_appended, sb.n_updated, sb.n_rejected, sb.n_removed);
    $display("%0d search hits, %0d misses, %0d unused codes; peak table fill %0d of %0d.",
             sb.n_hits, sb.n_misses, sb.n_unused, sb.peak, Depth);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
